/* rtl/ssc_pkg.sv */
// Shared types, constants, font tables and divide-by-ten helpers for the
// seven-segment scan controller. No dependencies.
`default_nettype none

package ssc_pkg;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 2;
  localparam int CODE_W   = 8;
  localparam int MASK_W   = 8;
  localparam int NUM_W    = 16;
  localparam int SEG_W    = 7;
  localparam int GRID_W   = 11;
  localparam int FRAME_W  = SEG_W + GRID_W;
  localparam int DIGIT_W  = 4;
  localparam int FONT_AW  = 7;
  localparam int FONT_DEPTH = 1 << FONT_AW;

  localparam logic [GRID_W-1:0] GRID_ALL_OFF = 11'h7FF;
  localparam logic [CODE_W-1:0] FONT_UNSET   = 8'hFF;
  localparam logic [SEG_W-1:0]  SEG_ZERO     = 7'h3F;

  // floor(n / 10) == (n * 52429) >> 19 for every 16-bit n
  localparam logic [31:0] DIV10_MUL   = 32'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR   = 3'd0,
    CMD_RAW    = 3'd1,
    CMD_DIGIT  = 3'd2,
    CMD_DEFINE = 3'd3,
    CMD_SHOW   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_SCAN   = 3'd6
  } cmd_e;

  localparam logic [SEG_W-1:0] DEC_FONT [16] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  localparam logic [SEG_W-1:0] ROM_FONT [FONT_DEPTH] = '{
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h06, 7'h22, 7'h76, 7'h00, 7'h00, 7'h00, 7'h02,
    7'h39, 7'h0F, 7'h00, 7'h00, 7'h04, 7'h40, 7'h08, 7'h52,
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
    7'h7F, 7'h6F, 7'h00, 7'h00, 7'h00, 7'h48, 7'h00, 7'h53,
    7'h00, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71, 7'h3D,
    7'h76, 7'h06, 7'h1E, 7'h75, 7'h38, 7'h79, 7'h54, 7'h3F,
    7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h3E, 7'h1C, 7'h4F,
    7'h76, 7'h6E, 7'h5B, 7'h39, 7'h00, 7'h0F, 7'h23, 7'h08,
    7'h20, 7'h5F, 7'h7C, 7'h58, 7'h5E, 7'h7B, 7'h71, 7'h6F,
    7'h74, 7'h04, 7'h0E, 7'h75, 7'h30, 7'h79, 7'h54, 7'h5C,
    7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h1C, 7'h1C, 7'h4F,
    7'h76, 7'h6E, 7'h5B, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  function automatic logic [NUM_W-1:0] div10(input logic [NUM_W-1:0] n);
    logic [31:0] prod;
    prod = 32'(n) * DIV10_MUL;
    return NUM_W'(prod >> DIV10_SHIFT);
  endfunction

  // remainder from a known quotient: n - 10*q
  function automatic logic [DIGIT_W-1:0] rem10(input logic [NUM_W-1:0] n,
                                               input logic [NUM_W-1:0] q);
    logic [NUM_W-1:0] r;
    r = n - ((q << 3) + (q << 1));
    return r[DIGIT_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/ssc_cmd_if.sv */
// Request channel of the seven-segment scan controller.
// Depends on ssc_pkg for field widths.
`default_nettype none

interface ssc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ssc_pkg::CMD_W-1:0]    command;
  logic [ssc_pkg::POS_W-1:0]    position;
  logic [ssc_pkg::CODE_W-1:0]   code;
  logic [ssc_pkg::MASK_W-1:0]   mask;
  logic [ssc_pkg::NUM_W-1:0]    number;

  modport source (output valid, command, position, code, mask, number, input ready);
  modport sink   (input valid, command, position, code, mask, number, output ready);
endinterface

`default_nettype wire

/* rtl/ssc_frame_if.sv */
// Driver-word channel of the seven-segment scan controller.
// Depends on ssc_pkg for field widths.
`default_nettype none

interface ssc_frame_if;
  logic                          valid;
  logic                          ready;
  logic [ssc_pkg::FRAME_W-1:0]   frame_word;
  logic [ssc_pkg::POS_W-1:0]     scanned_digit;

  modport source (output valid, frame_word, scanned_digit, input ready);
  modport sink   (input valid, frame_word, scanned_digit, output ready);
endinterface

`default_nettype wire

/* rtl/ssc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/seven_segment_scan_controller_core.sv */
// Top level of the seven-segment scan controller.
// Depends on ssc_pkg, ssc_cmd_if, ssc_frame_if and ssc_ram.
//
// Takes one request per clock while not stalled. A clear or scan-tick request
// yields a driver word, all other requests yield none; the word passes the
// divide-by-ten chain, one stage per decimal place, behind the input register
// and the font RAM read. The custom font is a 128 x 8 RAM with registered
// read plus one valid flop per entry, so it is usable right after reset with
// no clearing pass. Output is registered; the pipeline keeps accepting while
// a word waits, and stalls only behind it.
`default_nettype none

module seven_segment_scan_controller_core #(
  parameter int NUM_DIGITS = 4
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  ssc_cmd_if.sink      cmd_i,
  ssc_frame_if.source  frame_o
);

  import ssc_pkg::*;

  localparam int IDX_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam int ND    = NUM_DIGITS;

  typedef struct packed {
    cmd_e               cmd;
    logic [POS_W-1:0]   pos;
    logic [CODE_W-1:0]  code;
    logic [MASK_W-1:0]  mask;
    logic [NUM_W-1:0]   number;
  } req_t;

  typedef struct packed {
    cmd_e                           cmd;
    logic [POS_W-1:0]               pos;
    logic [SEG_W-1:0]               pat;
    logic [NUM_W-1:0]               quot;
    logic [ND-1:0][DIGIT_W-1:0]     dig;
  } stage_t;

  req_t                 in_q;
  logic                 in_vld_q;
  stage_t               st_q   [ND];
  stage_t               st_d   [ND];
  logic [ND-1:0]        st_vld_q;
  logic [ND-1:0]        st_rdy;
  logic                 in_rdy;
  logic                 accept;

  logic [FONT_DEPTH-1:0] font_set_q;
  logic                  byp_q;
  logic [CODE_W-1:0]     byp_data_q;
  logic [CODE_W-1:0]     ram_rdata;
  logic [CODE_W-1:0]     font_entry;
  logic [SEG_W-1:0]      char_pat;
  logic                  font_we;

  logic [SEG_W-1:0]      digits_q [ND];
  logic [IDX_W-1:0]      scan_q;

  stage_t                tail;
  logic                  tail_res;
  logic                  commit_ok;
  logic                  commit;
  logic                  pos_ok;
  logic [IDX_W-1:0]      pos_idx;
  logic [GRID_W-1:0]     grids;
  logic [FRAME_W-1:0]    word_d;
  logic [POS_W-1:0]      sdig_d;

  logic                  out_vld_q;
  logic [FRAME_W-1:0]    out_word_q;
  logic [POS_W-1:0]      out_sdig_q;

  // handshake and ready chain
  assign tail      = st_q[ND-1];
  assign tail_res  = (tail.cmd == CMD_CLEAR) || (tail.cmd == CMD_SCAN);
  assign commit_ok = !tail_res || !out_vld_q || frame_o.ready;
  assign commit    = st_vld_q[ND-1] && commit_ok;

  always_comb begin
    st_rdy[ND-1] = !st_vld_q[ND-1] || commit_ok;
    for (int k = ND - 2; k >= 0; k--) begin
      st_rdy[k] = !st_vld_q[k] || st_rdy[k+1];
    end
  end

  assign in_rdy      = !in_vld_q || st_rdy[0];
  assign cmd_i.ready = in_rdy;
  assign accept      = cmd_i.valid && in_rdy;

  // custom font
  assign font_we = in_vld_q && st_rdy[0] && (in_q.cmd == CMD_DEFINE) &&
                   !in_q.code[CODE_W-1];

  ssc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (FONT_DEPTH)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (font_we),
    .waddr_i (in_q.code[FONT_AW-1:0]),
    .wdata_i (in_q.mask),
    .re_i    (accept),
    .raddr_i (cmd_i.code[FONT_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (!font_set_q[in_q.code[FONT_AW-1:0]]) begin
      font_entry = FONT_UNSET;
    end else if (byp_q) begin
      font_entry = byp_data_q;
    end else begin
      font_entry = ram_rdata;
    end
    if (in_q.code[CODE_W-1]) begin
      char_pat = '0;
    end else if (font_entry == FONT_UNSET) begin
      char_pat = ROM_FONT[in_q.code[FONT_AW-1:0]];
    end else begin
      char_pat = font_entry[SEG_W-1:0];
    end
  end

  // divide-by-ten stages, units digit first
  always_comb begin
    logic [NUM_W-1:0] q;
    q = div10(in_q.number);
    st_d[0]        = '0;
    st_d[0].cmd    = in_q.cmd;
    st_d[0].pos    = in_q.pos;
    st_d[0].quot   = q;
    st_d[0].dig[0] = rem10(in_q.number, q);
    case (in_q.cmd)
      CMD_CHAR: st_d[0].pat = char_pat;
      CMD_RAW:  st_d[0].pat = in_q.mask[SEG_W-1:0];
      default:  st_d[0].pat = '0;
    endcase
    for (int k = 1; k < ND; k++) begin
      q              = div10(st_q[k-1].quot);
      st_d[k]        = st_q[k-1];
      st_d[k].quot   = q;
      st_d[k].dig[k] = rem10(st_q[k-1].quot, q);
    end
  end

  // driver word for the tail request
  assign pos_ok  = int'(tail.pos) < ND;
  assign pos_idx = IDX_W'(tail.pos);
  assign grids   = GRID_ALL_OFF & ~(GRID_W'(1) << (ND - int'(scan_q)));

  always_comb begin
    if (tail.cmd == CMD_CLEAR) begin
      word_d = {{SEG_W{1'b0}}, GRID_ALL_OFF};
      sdig_d = '0;
    end else begin
      word_d = {digits_q[scan_q], grids};
      sdig_d = POS_W'(scan_q);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      st_vld_q   <= '0;
      out_vld_q  <= 1'b0;
      font_set_q <= '0;
      scan_q     <= '0;
      for (int i = 0; i < ND; i++) begin
        digits_q[i] <= SEG_ZERO;
      end
    end else begin
      if (in_rdy) begin
        in_vld_q <= cmd_i.valid;
      end
      if (st_rdy[0]) begin
        st_vld_q[0] <= in_vld_q;
      end
      for (int k = 1; k < ND; k++) begin
        if (st_rdy[k]) begin
          st_vld_q[k] <= st_vld_q[k-1];
        end
      end
      if (font_we) begin
        font_set_q[in_q.code[FONT_AW-1:0]] <= 1'b1;
      end
      if (commit && tail_res) begin
        out_vld_q <= 1'b1;
      end else if (frame_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (commit) begin
        case (tail.cmd)
          CMD_CHAR, CMD_RAW: begin
            if (pos_ok) begin
              digits_q[pos_idx] <= tail.pat;
            end
          end
          CMD_DIGIT: begin
            if (pos_ok) begin
              digits_q[pos_idx] <= DEC_FONT[tail.dig[0]];
            end
          end
          CMD_SHOW: begin
            for (int i = 0; i < ND; i++) begin
              digits_q[i] <= DEC_FONT[tail.dig[ND-1-i]];
            end
          end
          CMD_CLEAR: begin
            for (int i = 0; i < ND; i++) begin
              digits_q[i] <= '0;
            end
          end
          CMD_SCAN: begin
            scan_q <= (int'(scan_q) == ND - 1) ? '0 : scan_q + 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q.cmd    <= cmd_e'(cmd_i.command);
      in_q.pos    <= cmd_i.position;
      in_q.code   <= cmd_i.code;
      in_q.mask   <= cmd_i.mask;
      in_q.number <= cmd_i.number;
      // same-edge write to the entry being read: take the new data
      byp_q       <= font_we && (in_q.code[FONT_AW-1:0] == cmd_i.code[FONT_AW-1:0]);
      byp_data_q  <= in_q.mask;
    end
    if (st_rdy[0]) begin
      st_q[0] <= st_d[0];
    end
    for (int k = 1; k < ND; k++) begin
      if (st_rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
    if (commit && tail_res) begin
      out_word_q <= word_d;
      out_sdig_q <= sdig_d;
    end
  end

  assign frame_o.valid         = out_vld_q;
  assign frame_o.frame_word    = out_word_q;
  assign frame_o.scanned_digit = out_sdig_q;

endmodule

`default_nettype wire

/* dv/seven_segment_scan_controller_core_test.sv */
// Self-checking testbench for seven_segment_scan_controller_core: directed table,
// then random requests with random idling on both channels, checked against a predictor.
// Depends on seven_segment_scan_controller_core, ssc_pkg, ssc_cmd_if and ssc_frame_if.
`default_nettype none

module seven_segment_scan_controller_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  localparam int NUM_DIGITS    = 4;
  localparam int RANDOM_ITEMS  = 600;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 4 * (NUM_DIGITS + 1);
  localparam logic [CMD_W-1:0] CMD_RESERVED = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [POS_W-1:0]  position;
    logic [CODE_W-1:0] code;
    logic [MASK_W-1:0] mask;
    logic [NUM_W-1:0]  number;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] word;
    logic [POS_W-1:0]   digit;
  } frame_t;

  typedef struct packed {
    req_t   req;
    bit     fixed;
    frame_t want;
  } row_t;

  localparam logic [6:0] DIGIT_GLYPH [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  localparam logic [7:0] GLYPH_ROM [128] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h86, 8'h22, 8'h76, 8'h00, 8'h00, 8'h00, 8'h02,
    8'h39, 8'h0F, 8'h00, 8'h00, 8'h04, 8'h40, 8'h08, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
    8'h00, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h06, 8'h1E, 8'h75, 8'h38, 8'h79, 8'h54, 8'h3F,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h1C, 8'h4F,
    8'h76, 8'h6E, 8'h5B, 8'h39, 8'h00, 8'h0F, 8'h23, 8'h08,
    8'h20, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
    8'h74, 8'h04, 8'h0E, 8'h75, 8'h30, 8'h79, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1C, 8'h4F,
    8'h76, 8'h6E, 8'h5B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ssc_cmd_if   cmd_if ();
  ssc_frame_if frame_if ();

  seven_segment_scan_controller_core #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_if),
    .frame_o (frame_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic [SEG_W-1:0] seg_state [NUM_DIGITS];
  logic [7:0]       user_glyphs [128];
  logic [POS_W-1:0] scan_pos;

  frame_t pending_frames [$];
  row_t   stim_rows [$];
  frame_t head_frame;
  int     mismatch_count = 0;
  int     idle_cycles = 0;
  int     sink_hold = 0;
  bit     quiet_phase = 1'b0;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Updates the display model; returns 1 when the request yields a driver word.
  function automatic bit step_display(input req_t r, output frame_t f);
    logic [7:0]        glyph;
    logic [NUM_W-1:0]  n;
    logic [GRID_W-1:0] grids;
    int i;
    f = '0;
    case (r.command)
      CMD_CHAR: begin
        if (r.code[7]) begin
          glyph = 8'h00;
        end else begin
          glyph = user_glyphs[r.code[6:0]];
          if (glyph == FONT_UNSET) glyph = GLYPH_ROM[r.code[6:0]];
        end
        if (r.position < NUM_DIGITS) seg_state[r.position] = glyph[6:0];
      end
      CMD_RAW: begin
        if (r.position < NUM_DIGITS) seg_state[r.position] = r.mask[6:0];
      end
      CMD_DIGIT: begin
        if (r.position < NUM_DIGITS) seg_state[r.position] = DIGIT_GLYPH[r.number % 10];
      end
      CMD_DEFINE: begin
        if (!r.code[7]) user_glyphs[r.code[6:0]] = r.mask;
      end
      CMD_SHOW: begin
        n = r.number;
        for (i = NUM_DIGITS - 1; i >= 0; i--) begin
          seg_state[i] = DIGIT_GLYPH[n % 10];
          n = n / 10;
        end
      end
      CMD_CLEAR: begin
        for (i = 0; i < NUM_DIGITS; i++) seg_state[i] = '0;
        f.word  = {{SEG_W{1'b0}}, GRID_ALL_OFF};
        f.digit = '0;
        return 1'b1;
      end
      CMD_SCAN: begin
        grids   = GRID_ALL_OFF & ~(GRID_W'(1) << (NUM_DIGITS - scan_pos));
        f.word  = {seg_state[scan_pos], grids};
        f.digit = scan_pos;
        scan_pos = POS_W'((scan_pos + 1) % NUM_DIGITS);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] command, input logic [POS_W-1:0] position,
                         input logic [CODE_W-1:0] code, input logic [MASK_W-1:0] mask,
                         input logic [NUM_W-1:0] number, input bit fixed,
                         input logic [FRAME_W-1:0] word, input logic [POS_W-1:0] digit);
    row_t row;
    row.req  = '{command, position, code, mask, number};
    row.fixed = fixed;
    row.want = '{word, digit};
    stim_rows.push_back(row);
  endtask

  task automatic issue_request(input req_t r, input bit drain_first, input bit use_fixed,
                               input frame_t fixed_frame);
    int     gap;
    frame_t f;
    gap = quiet_phase ? 0 : pick_gap();
    if (gap > 0 || drain_first) begin
      cmd_if.valid <= 1'b0;
      if (drain_first) begin
        do @(posedge clk_i); while (pending_frames.size() != 0);
      end
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.command  <= r.command;
    cmd_if.position <= r.position;
    cmd_if.code     <= r.code;
    cmd_if.mask     <= r.mask;
    cmd_if.number   <= r.number;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    if (step_display(r, f)) pending_frames.push_back(use_fixed ? fixed_frame : f);
  endtask

  // sink side: random back-pressure on the driver-word channel
  initial begin
    frame_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        frame_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        frame_if.ready <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 7) == 0) sink_hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected frame: expected none, actual word %h digit %0d",
                 $time, frame_if.frame_word, frame_if.scanned_digit);
        mismatch_count++;
      end else begin
        head_frame = pending_frames.pop_front();
        if (frame_if.frame_word !== head_frame.word) begin
          $display("%0t: frame_word mismatch: expected %h actual %h",
                   $time, head_frame.word, frame_if.frame_word);
          mismatch_count++;
        end
        if (frame_if.scanned_digit !== head_frame.digit) begin
          $display("%0t: scanned_digit mismatch: expected %0d actual %0d",
                   $time, head_frame.digit, frame_if.scanned_digit);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
          (frame_if.valid === 1'b1 && frame_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: watchdog expired with %0d frames pending", $time, pending_frames.size());
        $display("seven_segment_scan_controller_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    req_t r;
    int   counted;
    int   iter;
    int   roll;

    for (int i = 0; i < NUM_DIGITS; i++) seg_state[i] = SEG_ZERO;
    for (int i = 0; i < 128; i++) user_glyphs[i] = FONT_UNSET;
    scan_pos = '0;

    rst_ni          <= 1'b0;
    cmd_if.valid    <= 1'b0;
    cmd_if.command  <= '0;
    cmd_if.position <= '0;
    cmd_if.code     <= '0;
    cmd_if.mask     <= '0;
    cmd_if.number   <= '0;

    // reset state, clear, then grid walk with blank digits
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 1, 18'h1FFEF, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 1, 18'h1FFF7, 1);
    add_row(CMD_CLEAR,  0, 8'h00, 8'h00, 16'h0000, 1, 18'h007FF, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 1, 18'h007FB, 2);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 1, 18'h007FD, 3);
    // raw mask top bit dropped, built-in font, blank for high codes
    add_row(CMD_RAW,    0, 8'h00, 8'hFF, 16'h0000, 0, '0, 0);
    add_row(CMD_RAW,    3, 8'h00, 8'h80, 16'h0000, 0, '0, 0);
    add_row(CMD_CHAR,   1, 8'h21, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_CHAR,   2, 8'h80, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);
    // number overflow, custom glyphs, ignored define, digit extremes, reserved
    add_row(CMD_SHOW,   0, 8'h00, 8'h00, 16'hFFFF, 0, '0, 0);
    add_row(CMD_DEFINE, 0, 8'h41, 8'hAA, 16'h0000, 0, '0, 0);
    add_row(CMD_DEFINE, 0, 8'h80, 8'h12, 16'h0000, 0, '0, 0);
    add_row(CMD_CHAR,   0, 8'h41, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_DIGIT,  1, 8'h00, 8'h00, 16'hFFFF, 0, '0, 0);
    add_row(CMD_DIGIT,  2, 8'hFF, 8'hFF, 16'h0000, 0, '0, 0);
    add_row(CMD_RESERVED, 3, 8'hFF, 8'hFF, 16'hFFFF, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);
    add_row(CMD_SCAN,   0, 8'h00, 8'h00, 16'h0000, 0, '0, 0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      issue_request(stim_rows[i].req, 1'b0, stim_rows[i].fixed, stim_rows[i].want);
    end

    counted = 0;
    iter = 0;
    while (counted < RANDOM_ITEMS) begin
      quiet_phase = (counted >= 200 && counted < 300);
      roll = $urandom_range(0, 99);
      if      (roll < 28) r.command = CMD_SCAN;
      else if (roll < 33) r.command = CMD_CLEAR;
      else if (roll < 48) r.command = CMD_CHAR;
      else if (roll < 58) r.command = CMD_RAW;
      else if (roll < 68) r.command = CMD_DIGIT;
      else if (roll < 83) r.command = CMD_DEFINE;
      else if (roll < 95) r.command = CMD_SHOW;
      else                r.command = CMD_RESERVED;
      r.position = POS_W'($urandom_range(0, 3));
      // bias codes toward a small set so defined glyphs get shown
      if ($urandom_range(0, 1) == 0) r.code = CODE_W'($urandom_range(0, 255));
      else                           r.code = CODE_W'(8'h40 + $urandom_range(0, 7));
      if ($urandom_range(0, 6) == 0) r.mask = FONT_UNSET;
      else                           r.mask = MASK_W'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if      (roll < 40) r.number = NUM_W'($urandom_range(0, 65535));
      else if (roll < 70) r.number = NUM_W'($urandom_range(0, 9999));
      else                r.number = NUM_W'($urandom_range(0, 99));
      issue_request(r, iter == 400, 1'b0, '0);
      iter++;
      counted++;
    end
    quiet_phase = 1'b0;
    cmd_if.valid <= 1'b0;

    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_frames.size() == 0) begin
      $display("seven_segment_scan_controller_core verification clean");
    end else begin
      $display("seven_segment_scan_controller_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* seven_segment_scan_controller_core.f */
rtl/ssc_pkg.sv
rtl/ssc_cmd_if.sv
rtl/ssc_frame_if.sv
rtl/ssc_ram.sv
rtl/seven_segment_scan_controller_core.sv
dv/seven_segment_scan_controller_core_test.sv
